// ===== rtl/tcce_pkg.sv =====
// Shared types, constants and sizes of the text console character engine.
package tcce_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int PTR_W   = $clog2(CELLS + 1);
    localparam int OFS_W   = $clog2(32 * COLUMNS + 128);

    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [7:0]  CH_NL       = 8'd10;
    localparam logic [7:0]  CH_CR       = 8'd13;
    localparam logic [7:0]  CH_BS       = 8'd8;
    localparam logic [7:0]  CH_SPACE    = 8'h20;
    localparam logic [15:0] BLANK_CLEAR = 16'h0F20;
    localparam logic [7:0]  ATTR_RESET  = 8'h07;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] char_code;
        logic [6:0] column;
        logic [4:0] row;
        logic [7:0] attribute;
    } t_cmd_item;

    typedef struct packed {
        logic [6:0]  cursor_column;
        logic [4:0]  cursor_row;
        logic [10:0] cursor_offset;
        logic [7:0]  cell_char;
        logic [7:0]  cell_attr;
    } t_result_item;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_READ,
        S_SCROLL,
        S_FILL,
        S_CLEAR,
        S_DONE
    } t_state;

endpackage

// ===== rtl/tcce_cell_ram.sv =====
// Screen cell memory: one write port, one read port with registered read data.
module tcce_cell_ram
    import tcce_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [15:0]       i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [15:0]       o_rdata
);

    logic [15:0] r_mem [CELLS];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tcce_addr_unit.sv =====
// Shared position unit: linear cell offset of a row and column.
module tcce_addr_unit
    import tcce_pkg::*;
(
    input  logic [4:0]       i_row,
    input  logic [6:0]       i_col,
    output logic [OFS_W-1:0] o_lin
);

    assign o_lin = OFS_W'(i_row) * OFS_W'(COLUMNS) + OFS_W'(i_col);

endmodule

// ===== rtl/text_console_character_engine_unit.sv =====
// Top level of the text console character engine: sequencer, cursor and registers.
//
// Sequence: an accepted command passes a decode step and a result step before the result
// strobe rises; a read on the screen adds a read step, a scrolling put adds a copy of the
// upper rows through the single port pair and then a fill of the blank bottom row, and
// clear adds a pass over every cell. A new command is taken only while idle (busy low).
// Reset: synchronous, active low; a clearing pass then writes 0x0F20 into every cell
// with busy high. The receiver cannot stall: o_done marks each result once.
module text_console_character_engine_unit
    import tcce_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  t_cmd_item    i_cmd,
    input  logic         i_cfg_we,
    input  logic [7:0]   i_cfg_wdata,
    output logic         o_done,
    output t_result_item o_result
);

    // Sequencer and cursor state
    t_state       r_state,   n_state;
    logic [PTR_W-1:0] r_ptr, n_ptr;
    logic [6:0]   r_cur_col, n_cur_col;
    logic [4:0]   r_cur_row, n_cur_row;
    logic [7:0]   r_attr;

    // Captured command and read data
    t_cmd_item    r_req,     n_req;
    logic [7:0]   r_rd_char, n_rd_char;
    logic [7:0]   r_rd_attr, n_rd_attr;

    // Result register
    logic         r_done,    n_done;
    t_result_item r_result,  n_result;

    // Memory and shared position unit
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [15:0]       ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [15:0]       ram_rdata;
    logic [4:0]        au_row;
    logic [6:0]        au_col;
    logic [OFS_W-1:0]  au_lin;

    logic req_inside;
    logic is_bs;

    tcce_cell_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    tcce_addr_unit u_addr (
        .i_row (au_row),
        .i_col (au_col),
        .o_lin (au_lin)
    );

    assign req_inside = ({1'b0, r_req.column} < 8'(COLUMNS)) &&
                        ({1'b0, r_req.row} < 6'(ROWS));
    assign is_bs      = (r_req.char_code == CH_BS);

    // Point the shared unit at the cell that the current step touches
    always_comb begin
        au_row = r_cur_row;
        au_col = r_cur_col;
        if (r_state == S_DECODE) begin
            if (r_req.command == CMD_PUT) begin
                au_col = (is_bs && r_cur_col != 7'd0) ? r_cur_col - 7'd1 : r_cur_col;
            end else begin
                au_row = r_req.row;
                au_col = r_req.column;
            end
        end
    end

    // Next state and memory controls
    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        n_req     = r_req;
        n_rd_char = r_rd_char;
        n_rd_attr = r_rd_attr;
        n_done    = 1'b0;
        n_result  = r_result;
        ram_we    = 1'b0;
        ram_waddr = ADDR_W'(au_lin);
        ram_wdata = {r_attr, CH_SPACE};
        ram_raddr = ADDR_W'(au_lin);

        unique case (r_state)
            S_INIT, S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr[ADDR_W-1:0];
                ram_wdata = BLANK_CLEAR;
                if (r_ptr == PTR_W'(CELLS - 1)) begin
                    n_ptr   = '0;
                    n_state = (r_state == S_INIT) ? S_IDLE : S_DONE;
                end else begin
                    n_ptr = r_ptr + PTR_W'(1);
                end
            end

            S_IDLE: begin
                if (start) begin
                    n_req   = i_cmd;
                    n_state = S_DECODE;
                end
            end

            S_DECODE: begin
                n_rd_char = '0;
                n_rd_attr = '0;
                n_state   = S_DONE;
                unique case (r_req.command)
                    CMD_PUT: begin
                        priority if (r_req.char_code == CH_NL) begin
                            n_cur_col = '0;
                            if (r_cur_row == 5'(ROWS - 1)) begin
                                n_ptr   = PTR_W'(COLUMNS);
                                n_state = S_SCROLL;
                            end else begin
                                n_cur_row = r_cur_row + 5'd1;
                            end
                        end else if (r_req.char_code == CH_CR) begin
                            n_cur_col = '0;
                        end else if (is_bs) begin
                            // Step back and blank the cell; nothing at the left edge
                            if (r_cur_col != 7'd0) begin
                                n_cur_col = r_cur_col - 7'd1;
                                ram_we    = 1'b1;
                                ram_wdata = {r_attr, CH_SPACE};
                            end
                        end else begin
                            ram_we    = 1'b1;
                            ram_wdata = {r_attr, r_req.char_code};
                            if (r_cur_col == 7'(COLUMNS - 1)) begin
                                n_cur_col = '0;
                                if (r_cur_row == 5'(ROWS - 1)) begin
                                    n_ptr   = PTR_W'(COLUMNS);
                                    n_state = S_SCROLL;
                                end else begin
                                    n_cur_row = r_cur_row + 5'd1;
                                end
                            end else begin
                                n_cur_col = r_cur_col + 7'd1;
                            end
                        end
                    end
                    CMD_WRITE: begin
                        ram_we    = req_inside;
                        ram_wdata = {r_req.attribute, r_req.char_code};
                    end
                    CMD_READ: begin
                        if (req_inside) begin
                            n_state = S_READ;
                        end
                    end
                    CMD_CLEAR: begin
                        n_cur_col = '0;
                        n_cur_row = '0;
                        n_ptr     = '0;
                        n_state   = S_CLEAR;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            S_READ: begin
                n_rd_char = ram_rdata[7:0];
                n_rd_attr = ram_rdata[15:8];
                n_state   = S_DONE;
            end

            S_SCROLL: begin
                // Read one cell ahead, write the one read last cycle a row higher
                ram_raddr = r_ptr[ADDR_W-1:0];
                if (r_ptr > PTR_W'(COLUMNS)) begin
                    ram_we    = 1'b1;
                    ram_waddr = ADDR_W'(r_ptr - PTR_W'(COLUMNS + 1));
                    ram_wdata = ram_rdata;
                end
                if (r_ptr == PTR_W'(CELLS)) begin
                    n_ptr   = PTR_W'(CELLS - COLUMNS);
                    n_state = S_FILL;
                end else begin
                    n_ptr = r_ptr + PTR_W'(1);
                end
            end

            S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr[ADDR_W-1:0];
                ram_wdata = {r_attr, CH_SPACE};
                if (r_ptr == PTR_W'(CELLS - 1)) begin
                    n_ptr   = '0;
                    n_state = S_DONE;
                end else begin
                    n_ptr = r_ptr + PTR_W'(1);
                end
            end

            S_DONE: begin
                n_done   = 1'b1;
                n_result = '{cursor_column: r_cur_col,
                             cursor_row:    r_cur_row,
                             cursor_offset: 11'(au_lin),
                             cell_char:     r_rd_char,
                             cell_attr:     r_rd_attr};
                n_state  = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_ptr     <= '0;
            r_cur_col <= '0;
            r_cur_row <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ptr     <= n_ptr;
            r_cur_col <= n_cur_col;
            r_cur_row <= n_cur_row;
            r_done    <= n_done;
        end
    end

    // Default attribute register: taken on every write enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (i_cfg_we) begin
            r_attr <= i_cfg_wdata;
        end
    end

    // Payload registers hold without reset
    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_rd_char <= n_rd_char;
        r_rd_attr <= n_rd_attr;
        r_result  <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    a_accept_goes_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transfer did not raise busy");

    a_done_follows_done_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state) == S_DONE)
        else $error("result strobe without result step");

    a_cursor_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_cur_col} < 8'(COLUMNS)) && ({1'b0, r_cur_row} < 6'(ROWS)))
        else $error("cursor outside the screen");

    a_no_write_when_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> busy)
        else $error("cell memory written while idle");

endmodule
